// ===== hdl/chse_pkg.sv =====
// shared types, constants and codes of the chained hash set engine
package chse_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int HASH_W   = 32;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = SLOT_W + 1;
  localparam int CNT_W    = SLOT_W + 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam logic [LINK_W-1:0] CHAIN_END = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {OP_INSERT, OP_LOOKUP, OP_REMOVE} op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_BITS-1:0] key;
    logic [HASH_W-1:0]   hash;
  } req_item_t;

  typedef struct packed {
    logic      valid;
    req_item_t item;
  } queue_out_t;

  typedef struct packed {
    logic                vld;
    logic [LINK_W-1:0]   link;
    logic [HASH_W-1:0]   hash;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_FREE, ST_WALK, ST_NXT, ST_WR1, ST_WR2, ST_DONE
  } state_t;

endpackage

// ===== hdl/chse_req_if.sv =====
// request channel interface
interface chse_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [chse_pkg::KEY_W-1:0]  key;
  logic [chse_pkg::HASH_W-1:0] key_hash;

  modport source (output valid, req_type, key, key_hash, input ready);
  modport sink (input valid, req_type, key, key_hash, output ready);
endinterface

// ===== hdl/chse_res_if.sv =====
// result channel interface
interface chse_res_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [chse_pkg::SLOT_W-1:0] slot;
  logic                       status;
  logic [chse_pkg::CNT_W-1:0]  entry_count;

  modport source (output valid, found, slot, status, entry_count, input ready);
  modport sink (input valid, found, slot, status, entry_count, output ready);
endinterface

// ===== hdl/chse_ram.sv =====
// generic single write port, single read port ram with registered read
module chse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chse_front.sv =====
// front end: accepts and decodes requests into a two entry queue
module chse_front (
  input  logic                clk,
  input  logic                rst,
  chse_req_if.sink            req,
  input  logic                clearing,
  input  logic                pop,
  output chse_pkg::queue_out_t q
);

  chse_pkg::req_item_t buf_q [2];
  chse_pkg::req_item_t item_in;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       take;

  always_comb begin
    item_in.key  = req.key[chse_pkg::KEY_BITS-1:0];
    item_in.hash = req.key_hash;
    unique case (req.req_type)
      chse_pkg::REQ_INSERT: item_in.op = chse_pkg::OP_INSERT;
      chse_pkg::REQ_REMOVE: item_in.op = chse_pkg::OP_REMOVE;
      default:              item_in.op = chse_pkg::OP_LOOKUP;
    endcase
  end

  assign req.ready = (cnt != 2'd2) && !clearing;
  assign push      = req.valid && req.ready;
  assign take      = pop && (cnt != 2'd0);
  assign q.valid   = (cnt != 2'd0);
  assign q.item    = buf_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

// ===== hdl/chse_back.sv =====
// back end: sequencer that walks chains and updates the table
module chse_back (
  input  logic                                clk,
  input  logic                                rst,
  input  chse_pkg::queue_out_t                q,
  output logic                                pop,
  output logic                                clearing,
  chse_res_if.source                          res,
  output logic                                we,
  output logic [chse_pkg::SLOT_W-1:0]         waddr,
  output logic [chse_pkg::ENTRY_W-1:0]        wdata,
  output logic [chse_pkg::SLOT_W-1:0]         raddr,
  input  logic [chse_pkg::ENTRY_W-1:0]        rdata
);

  chse_pkg::state_t state;
  chse_pkg::state_t state_next;

  chse_pkg::op_t                 op;
  logic [chse_pkg::KEY_BITS-1:0] k;
  logic [chse_pkg::HASH_W-1:0]   h;
  logic [chse_pkg::SLOT_W-1:0]   cur;
  logic [chse_pkg::SLOT_W-1:0]   prv;
  logic                          prv_ok;
  logic                          first;
  chse_pkg::entry_t              prv_ent;
  chse_pkg::entry_t              home_ent;
  logic [chse_pkg::SLOT_W-1:0]   walk;
  logic [chse_pkg::SLOT_W-1:0]   fptr;
  logic [chse_pkg::SLOT_W-1:0]   clr;
  logic [chse_pkg::CNT_W-1:0]    count;
  logic [chse_pkg::SLOT_W-1:0]   w1a;
  logic [chse_pkg::SLOT_W-1:0]   w2a;
  chse_pkg::entry_t              w1d;
  chse_pkg::entry_t              w2d;
  logic                          r_found;
  logic [chse_pkg::SLOT_W-1:0]   r_slot;
  logic                          r_status;

  chse_pkg::entry_t              rd;
  chse_pkg::entry_t              home_e;
  chse_pkg::entry_t              new_ent;
  chse_pkg::entry_t              walk_upd;
  chse_pkg::entry_t              prv_upd;
  chse_pkg::entry_t              home_upd;
  chse_pkg::entry_t              chain_ent;
  logic [chse_pkg::SLOT_W-1:0]   home;
  logic [chse_pkg::SLOT_W-1:0]   rd_next;
  logic [chse_pkg::SLOT_W-1:0]   from;
  logic                          hit;
  logic                          lk_end;
  logic                          look_done;
  logic                          res_load;

  assign rd        = chse_pkg::entry_t'(rdata);
  assign home      = h[chse_pkg::SLOT_W-1:0];
  assign home_e    = first ? rd : home_ent;
  assign hit       = rd.vld && (rd.hash == h) && (rd.key == k);
  assign lk_end    = rd.link[chse_pkg::SLOT_W];
  assign rd_next   = rd.link[chse_pkg::SLOT_W-1:0];
  assign look_done = (first && !rd.vld) || hit || lk_end;
  assign from      = home_ent.hash[chse_pkg::SLOT_W-1:0];
  assign clearing  = (state == chse_pkg::ST_CLEAR);
  assign res_load  = (state == chse_pkg::ST_DONE) && (!res.valid || res.ready);

  always_comb begin
    new_ent.vld  = 1'b1;
    new_ent.link = chse_pkg::CHAIN_END;
    new_ent.hash = h;
    new_ent.key  = k;
    walk_upd      = rd;
    walk_upd.link = {1'b0, fptr};
    prv_upd       = prv_ent;
    prv_upd.link  = rd.link;
    home_upd      = home_ent;
    home_upd.link = {1'b0, fptr};
    chain_ent      = new_ent;
    chain_ent.link = home_ent.link;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chse_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = w1a;
    wdata      = w1d;
    raddr      = fptr;
    pop        = 1'b0;
    unique case (state)
      chse_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
        if (clr == chse_pkg::SLOT_W'(chse_pkg::CAPACITY - 1)) begin
          state_next = chse_pkg::ST_IDLE;
        end
      end
      chse_pkg::ST_IDLE: begin
        raddr = q.item.hash[chse_pkg::SLOT_W-1:0];
        if (q.valid) begin
          pop        = 1'b1;
          state_next = chse_pkg::ST_LOOK;
        end
      end
      chse_pkg::ST_LOOK: begin
        if (!look_done) begin
          raddr = rd_next;
        end else begin
          case (op)
            chse_pkg::OP_INSERT: begin
              if (hit || count == chse_pkg::FULL_CNT) begin
                state_next = chse_pkg::ST_DONE;
              end else if (!home_e.vld) begin
                we         = 1'b1;
                waddr      = home;
                wdata      = new_ent;
                state_next = chse_pkg::ST_DONE;
              end else begin
                raddr      = fptr;
                state_next = chse_pkg::ST_FREE;
              end
            end
            chse_pkg::OP_REMOVE: begin
              if (!hit) begin
                state_next = chse_pkg::ST_DONE;
              end else if (prv_ok) begin
                state_next = chse_pkg::ST_WR1;
              end else if (!lk_end) begin
                raddr      = rd_next;
                state_next = chse_pkg::ST_NXT;
              end else begin
                we         = 1'b1;
                waddr      = cur;
                wdata      = '0;
                state_next = chse_pkg::ST_DONE;
              end
            end
            default: state_next = chse_pkg::ST_DONE;
          endcase
        end
      end
      chse_pkg::ST_FREE: begin
        if (rd.vld) begin
          raddr = fptr + 1'b1;
        end else if (from == home) begin
          state_next = chse_pkg::ST_WR1;
        end else begin
          raddr      = from;
          state_next = chse_pkg::ST_WALK;
        end
      end
      chse_pkg::ST_WALK: begin
        if (rd.link == {1'b0, home}) begin
          we         = 1'b1;
          waddr      = walk;
          wdata      = walk_upd;
          state_next = chse_pkg::ST_WR1;
        end else if (lk_end) begin
          state_next = chse_pkg::ST_WR1;
        end else begin
          raddr = rd_next;
        end
      end
      chse_pkg::ST_NXT: state_next = chse_pkg::ST_WR1;
      chse_pkg::ST_WR1: begin
        we         = 1'b1;
        waddr      = w1a;
        wdata      = w1d;
        state_next = chse_pkg::ST_WR2;
      end
      chse_pkg::ST_WR2: begin
        we         = 1'b1;
        waddr      = w2a;
        wdata      = w2d;
        state_next = chse_pkg::ST_DONE;
      end
      chse_pkg::ST_DONE: begin
        if (!res.valid || res.ready) begin
          state_next = chse_pkg::ST_IDLE;
        end
      end
      default: state_next = chse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fptr      <= '0;
      count     <= '0;
      clr       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res_load) begin
        res.valid       <= 1'b1;
        res.found       <= r_found;
        res.slot        <= r_slot;
        res.status      <= r_status;
        res.entry_count <= count;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        chse_pkg::ST_CLEAR: clr <= clr + 1'b1;
        chse_pkg::ST_IDLE: begin
          if (q.valid) begin
            op     <= q.item.op;
            k      <= q.item.key;
            h      <= q.item.hash;
            cur    <= q.item.hash[chse_pkg::SLOT_W-1:0];
            prv_ok <= 1'b0;
            first  <= 1'b1;
          end
        end
        chse_pkg::ST_LOOK: begin
          first <= 1'b0;
          if (first) begin
            home_ent <= rd;
          end
          if (!look_done) begin
            prv     <= cur;
            prv_ent <= rd;
            prv_ok  <= 1'b1;
            cur     <= rd_next;
          end else begin
            r_found  <= hit;
            r_status <= (op == chse_pkg::OP_INSERT) && !hit &&
                        (count == chse_pkg::FULL_CNT);
            case (op)
              chse_pkg::OP_INSERT: begin
                if (hit) begin
                  r_slot <= cur;
                end else if (count == chse_pkg::FULL_CNT) begin
                  r_slot <= '0;
                end else if (!home_e.vld) begin
                  count  <= count + 1'b1;
                  r_slot <= home;
                end else begin
                  r_slot <= '0;
                end
              end
              chse_pkg::OP_REMOVE: begin
                r_slot <= '0;
                if (hit) begin
                  count       <= count - 1'b1;
                  w1a         <= prv;
                  w1d         <= prv_upd;
                  w2a         <= prv_ok ? cur : rd_next;
                  w2d         <= '0;
                end
              end
              default: begin
                r_slot <= hit ? cur : '0;
              end
            endcase
          end
        end
        chse_pkg::ST_FREE: begin
          if (rd.vld) begin
            fptr <= fptr + 1'b1;
          end else begin
            count <= count + 1'b1;
            if (from == home) begin
              r_slot     <= fptr;
              w1a        <= home;
              w1d        <= home_upd;
              w2a        <= fptr;
              w2d        <= chain_ent;
            end else begin
              r_slot     <= home;
              walk       <= from;
              w1a        <= fptr;
              w1d        <= home_ent;
              w2a        <= home;
              w2d        <= new_ent;
            end
          end
        end
        chse_pkg::ST_WALK: begin
          if (rd.link != {1'b0, home} && !lk_end) begin
            walk <= rd_next;
          end
        end
        chse_pkg::ST_NXT: begin
          w1a      <= cur;
          w1d      <= rd;
        end
        default: ;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= chse_pkg::FULL_CNT) else $error("entry count above capacity");

  a_free_room: assert property (@(posedge clk) disable iff (rst)
    state == chse_pkg::ST_FREE |-> count < chse_pkg::FULL_CNT)
    else $error("free slot scan with full table");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status |-> !res.found && res.slot == '0)
    else $error("rejected insert reports a slot");

  a_no_reclear: assert property (@(posedge clk) disable iff (rst)
    state != chse_pkg::ST_CLEAR |=> state != chse_pkg::ST_CLEAR)
    else $error("clearing pass restarted");

endmodule

// ===== hdl/chained_hash_set_engine.sv =====
// top level of the chained hash set engine
// Usage: requests enter on the req channel (req_type, key, key_hash) with a
// valid/ready handshake; one result per request leaves on the res channel
// (found, slot, status, entry_count) in request order.
// After reset the table's valid marks are cleared by a pass over all 1024
// slots, one slot per cycle; req.ready stays low during that pass.
// A two entry queue parts the request decoder from the table sequencer.
// Each request is dispatched, reads its home slot, follows its chain node by
// node as far as needed and then yields its result. An insert whose home slot
// is taken also scans for a free slot, walks the chain of a foreign entry
// when it relocates that entry, and makes two writes. Removal of a node with
// a predecessor adds two writes; removal of a chain head with a successor
// copies the successor into the head slot and then clears the successor's
// slot. All table accesses share one ram read port and one write port.
// Results sit in an output register; while the receiver stalls, the
// sequencer holds its finished result and the queue still takes up to two
// more requests before req.ready falls.
module chained_hash_set_engine (
  input  logic clk,
  input  logic rst,
  chse_req_if.sink   req,
  chse_res_if.source res
);

  chse_pkg::queue_out_t            q;
  logic                            pop;
  logic                            clearing;
  logic                            we;
  logic [chse_pkg::SLOT_W-1:0]     waddr;
  logic [chse_pkg::ENTRY_W-1:0]    wdata;
  logic [chse_pkg::SLOT_W-1:0]     raddr;
  logic [chse_pkg::ENTRY_W-1:0]    rdata;

  chse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .clearing (clearing),
    .pop      (pop),
    .q        (q)
  );

  chse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q        (q),
    .pop      (pop),
    .clearing (clearing),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  chse_ram #(
    .WIDTH (chse_pkg::ENTRY_W),
    .DEPTH (chse_pkg::CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
